/* src/spq_pkg.sv */
package spq_pkg;

   // Default depth of the queue
   localparam int CAPACITY_DEF = 16;

   // Field widths
   localparam int PRIO_W   = 8;
   localparam int DATA_W   = 32;
   localparam int OCC_W    = 5;
   localparam int STATUS_W = 2;

   // One stored entry
   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [DATA_W-1:0] data;
   } entry_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Request modes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_CMP,
      ST_PUT
   } state_type;

endpackage

/* src/spq_mem.sv */
module spq_mem
   import spq_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int AW    = $clog2(CAPACITY_DEF)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_entry,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_entry
);

   entry_type slot_mem [DEPTH];
   entry_type rd_entry_ff;

   // Single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_entry;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_entry_ff <= slot_mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

/* src/spq_ctrl.sv */
module spq_ctrl
   import spq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int AW       = $clog2(CAPACITY_DEF)
) (
   input  logic                clock,
   input  logic                reset,
   // request side
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [PRIO_W-1:0]   req_priority_req,
   input  logic [DATA_W-1:0]   req_payload,
   // result side
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PRIO_W-1:0]   rsp_out_priority,
   output logic [DATA_W-1:0]   rsp_out_payload,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [OCC_W-1:0]    rsp_occupancy,
   output logic                rsp_is_empty,
   // memory access
   output logic                mem_wr_en,
   output logic [AW-1:0]       mem_wr_addr,
   output entry_type           mem_wr_entry,
   output logic [AW-1:0]       mem_rd_addr,
   input  entry_type           mem_rd_entry
);

   localparam int CW = $clog2(CAPACITY + 1);

   state_type           state_ff, state_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [AW-1:0]       tail_ff, tail_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       wpos_ff, wpos_in;
   logic [CW-1:0]       left_ff, left_in;
   logic [PRIO_W-1:0]   pr_ff, pr_in;
   logic [DATA_W-1:0]   data_ff, data_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PRIO_W-1:0]   rsp_prio_ff, rsp_prio_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [CW-1:0]       rsp_count_ff, rsp_count_in;

   logic                accept;
   logic                is_full;
   logic                is_zero;
   logic                shift_hit;
   logic [AW-1:0]       tail_prev;
   logic [AW-1:0]       wpos_prev;
   logic [AW-1:0]       wpos_prev2;

   // Circular index step with wrap at CAPACITY
   function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
      return (p == '0) ? AW'(CAPACITY - 1) : p - 1'b1;
   endfunction

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == AW'(CAPACITY - 1)) ? '0 : p + 1'b1;
   endfunction

   // Take a new item only when idle and the result register is free
   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;
   assign is_full    = (count_ff == CW'(CAPACITY));
   assign is_zero    = (count_ff == '0);
   assign shift_hit  = (mem_rd_entry.prio < pr_ff);
   assign tail_prev  = wrap_dec(tail_ff);
   assign wpos_prev  = wrap_dec(wpos_ff);
   assign wpos_prev2 = wrap_dec(wpos_prev);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_REMOVE) begin
                  if (!is_zero) begin
                     state_in = ST_POP;
                  end
               end else if (!is_full && !is_zero) begin
                  state_in = ST_CMP;
               end
            end
         end
         ST_POP: begin
            state_in = ST_IDLE;
         end
         ST_CMP: begin
            if (!shift_hit) begin
               state_in = ST_IDLE;
            end else if (left_ff == CW'(1)) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, memory access and result loading
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      wpos_in       = wpos_ff;
      left_in       = left_ff;
      pr_in         = pr_ff;
      data_in       = data_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = wpos_ff;
      mem_wr_entry  = '{prio: pr_ff, data: data_ff};
      mem_rd_addr   = head_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pr_in   = req_priority_req;
               data_in = req_payload;
               wpos_in = tail_ff;
               left_in = count_ff;
               if (req_mode == MODE_REMOVE) begin
                  mem_rd_addr = head_ff;
                  if (is_zero) begin
                     rsp_valid_in  = 1'b1;
                     rsp_prio_in   = '0;
                     rsp_data_in   = '0;
                     rsp_status_in = STATUS_EMPTY;
                     rsp_count_in  = count_ff;
                  end
               end else if (is_full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_prio_in   = '0;
                  rsp_data_in   = '0;
                  rsp_status_in = STATUS_FULL;
                  rsp_count_in  = count_ff;
               end else if (is_zero) begin
                  // empty queue: the item goes straight to the tail
                  mem_wr_en     = 1'b1;
                  mem_wr_addr   = tail_ff;
                  mem_wr_entry  = '{prio: req_priority_req, data: req_payload};
                  tail_in       = wrap_inc(tail_ff);
                  count_in      = count_ff + 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_prio_in   = '0;
                  rsp_data_in   = '0;
                  rsp_status_in = STATUS_OK;
                  rsp_count_in  = count_ff + 1'b1;
               end else begin
                  // start scanning backward from the last entry
                  mem_rd_addr = tail_prev;
               end
            end
         end
         ST_POP: begin
            head_in       = wrap_inc(head_ff);
            count_in      = count_ff - 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_prio_in   = mem_rd_entry.prio;
            rsp_data_in   = mem_rd_entry.data;
            rsp_status_in = STATUS_OK;
            rsp_count_in  = count_ff - 1'b1;
         end
         ST_CMP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = wpos_ff;
            if (shift_hit) begin
               // lower priority: move it down one slot, read the next one up
               mem_wr_entry = mem_rd_entry;
               wpos_in      = wpos_prev;
               left_in      = left_ff - 1'b1;
               mem_rd_addr  = wpos_prev2;
            end else begin
               tail_in       = wrap_inc(tail_ff);
               count_in      = count_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_prio_in   = '0;
               rsp_data_in   = '0;
               rsp_status_in = STATUS_OK;
               rsp_count_in  = count_ff + 1'b1;
            end
         end
         ST_PUT: begin
            // new item lands at the head end
            mem_wr_en     = 1'b1;
            mem_wr_addr   = wpos_ff;
            tail_in       = wrap_inc(tail_ff);
            count_in      = count_ff + 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_prio_in   = '0;
            rsp_data_in   = '0;
            rsp_status_in = STATUS_OK;
            rsp_count_in  = count_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      wpos_ff       <= wpos_in;
      left_ff       <= left_in;
      pr_ff         <= pr_in;
      data_ff       <= data_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_out_payload  = rsp_data_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_occupancy    = OCC_W'(rsp_count_ff);
   assign rsp_is_empty     = (rsp_count_ff == '0);

endmodule

/* src/sorted_priority_queue_core.sv */
// Result path: a rejected item or an insert into an empty queue is answered from ST_IDLE,
// a remove from ST_POP, any other insert from ST_CMP or ST_PUT after its entry scan.
// One item at a time; the entry scan does one memory read and one write per cycle.
// Next item is taken once the controller is idle and the result register is free.
// Reset clears head, tail and count; the entry memory keeps its contents.
module sorted_priority_queue_core
   import spq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [PRIO_W-1:0]   req_priority_req,
   input  logic [DATA_W-1:0]   req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PRIO_W-1:0]   rsp_out_priority,
   output logic [DATA_W-1:0]   rsp_out_payload,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [OCC_W-1:0]    rsp_occupancy,
   output logic                rsp_is_empty
);

   localparam int AW = $clog2(CAPACITY);

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   entry_type     mem_wr_entry;
   logic [AW-1:0] mem_rd_addr;
   entry_type     mem_rd_entry;

   spq_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_priority_req (req_priority_req),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_is_empty     (rsp_is_empty),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_entry     (mem_wr_entry),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_entry     (mem_rd_entry)
   );

   spq_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_entry (mem_wr_entry),
      .rd_addr  (mem_rd_addr),
      .rd_entry (mem_rd_entry)
   );

endmodule
